// ===== src/stereo_pair_ring_fifo_macros.svh =====
// assertion macros for the stereo pair ring fifo checker
// expects signals named clk and rst in the scope of use
`ifndef STEREO_PAIR_RING_FIFO_MACROS_SVH
`define STEREO_PAIR_RING_FIFO_MACROS_SVH

// clocked assertion, off while reset is high
`define SPRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SPRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sprf_pkg.sv =====
// shared types and constants of the stereo pair ring fifo
// no dependencies
`timescale 1ns / 1ps

package sprf_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int MAX_READ_DEF   = 64;
  localparam int SAMPLE_W       = 32;
  localparam int COUNT_W        = 7;
  localparam int DROP_W         = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic                pair_complete;
    logic                end_of_write;
    logic [COUNT_W-1:0]  max_count;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                has_sample;
    logic                last;
    logic [COUNT_W-1:0]  read_total;
    logic [DROP_W-1:0]   dropped_total;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_R,
    ST_LOAD,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic wr_right;
    logic rd_issue;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic commit;
    logic read_empty;
    logic out_last;
  } status_t;

endpackage

// ===== src/sprf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sprf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sprf_ctrl.sv =====
// controller state machine of the stereo pair ring fifo
// depends on sprf_pkg
`timescale 1ns / 1ps

module sprf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sprf_pkg::status_t status,
  output sprf_pkg::cmd_t    cmd
);

  sprf_pkg::state_t state;
  sprf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sprf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      sprf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.is_read) begin
            if (status.commit) begin
              state_next = sprf_pkg::ST_WR_R;
            end
          end else if (status.read_empty) begin
            state_next = sprf_pkg::ST_HOLD;
          end else begin
            cmd.rd_issue = 1'b1;
            state_next   = sprf_pkg::ST_LOAD;
          end
        end
      end
      sprf_pkg::ST_WR_R: begin
        cmd.wr_right = 1'b1;
        state_next   = sprf_pkg::ST_IDLE;
      end
      sprf_pkg::ST_LOAD: begin
        cmd.rd_load = 1'b1;
        state_next  = sprf_pkg::ST_HOLD;
      end
      sprf_pkg::ST_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.out_last) begin
            state_next = sprf_pkg::ST_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
            state_next   = sprf_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = sprf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sprf_dp.sv =====
// datapath of the stereo pair ring fifo: pointers, drop counter, ring ram, output register
// depends on sprf_pkg and sprf_ram
`timescale 1ns / 1ps

module sprf_dp #(
  parameter int RING_DEPTH = sprf_pkg::RING_DEPTH_DEF,
  parameter int MAX_READ   = sprf_pkg::MAX_READ_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sprf_pkg::in_word_t  in_data,
  input  sprf_pkg::cmd_t      cmd,
  output sprf_pkg::status_t   status,
  output sprf_pkg::out_word_t out_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(MAX_READ + 1);
  localparam int CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

  logic [PTR_W-1:0]             wp;
  logic [PTR_W-1:0]             rp;
  logic [sprf_pkg::DROP_W-1:0]  drop_cnt;
  logic                         dropping;
  logic [sprf_pkg::SAMPLE_W-1:0] right_hold;
  logic [CNT_W-1:0]             n_reg;
  logic [CNT_W-1:0]             k;

  logic [PTR_W-1:0]             wp_n1;
  logic [PTR_W-1:0]             wp_n2;
  logic [PTR_W-1:0]             rp_n1;
  logic [PTR_W:0]               used;
  logic [CNT_W-1:0]             req_sat;
  logic [CNT_W-1:0]             req_even;
  logic [CMP_W-1:0]             used_c;
  logic [CMP_W-1:0]             req_c;
  logic [CMP_W-1:0]             n_min;
  logic [CNT_W-1:0]             n_cur;
  logic [CNT_W-1:0]             k_inc;
  logic                         full;
  logic                         is_write;

  logic                         ram_we;
  logic [PTR_W-1:0]             ram_waddr;
  logic [sprf_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [sprf_pkg::SAMPLE_W-1:0] ram_rdata;

  always_comb begin
    wp_n1 = (wp == LAST_PTR) ? '0 : wp + PTR_W'(1);
    wp_n2 = (wp_n1 == LAST_PTR) ? '0 : wp_n1 + PTR_W'(1);
    rp_n1 = (rp == LAST_PTR) ? '0 : rp + PTR_W'(1);
    full  = (wp_n1 == rp) || (wp_n2 == rp);

    if (wp >= rp) begin
      used = {1'b0, wp} - {1'b0, rp};
    end else begin
      used = {1'b0, wp} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp};
    end

    if (in_data.max_count > sprf_pkg::COUNT_W'(MAX_READ)) begin
      req_sat = CNT_W'(MAX_READ);
    end else begin
      req_sat = in_data.max_count[CNT_W-1:0];
    end
    req_even = req_sat & ~CNT_W'(1);
    used_c   = CMP_W'(used);
    req_c    = CMP_W'(req_even);
    n_min    = (used_c < req_c) ? used_c : req_c;
    n_cur    = CNT_W'(n_min) & ~CNT_W'(1);
    k_inc    = k + CNT_W'(1);

    is_write          = (in_data.opcode == sprf_pkg::OP_WRITE);
    status.is_read    = (in_data.opcode == sprf_pkg::OP_READ);
    status.commit     = in_data.pair_complete && !dropping && !full;
    status.read_empty = (n_cur == '0);
    status.out_last   = out_data.last;

    ram_we    = (cmd.accept && is_write && status.commit) || cmd.wr_right;
    ram_waddr = cmd.wr_right ? wp_n1 : wp;
    ram_wdata = cmd.wr_right ? right_hold : in_data.left_sample;
  end

  sprf_ram #(
    .WIDTH (sprf_pkg::SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      drop_cnt <= '0;
      dropping <= 1'b0;
    end else begin
      if (cmd.accept && is_write) begin
        if (!in_data.pair_complete) begin
          drop_cnt <= drop_cnt + sprf_pkg::DROP_W'(1);
        end else if (dropping) begin
          drop_cnt <= drop_cnt + sprf_pkg::DROP_W'(2);
        end else if (full) begin
          drop_cnt <= drop_cnt + sprf_pkg::DROP_W'(2);
        end
        if (in_data.end_of_write) begin
          dropping <= 1'b0;
        end else if (in_data.pair_complete && !dropping && full) begin
          dropping <= 1'b1;
        end
      end
      if (cmd.wr_right) begin
        wp <= wp_n2;
      end
      if (cmd.rd_load) begin
        rp <= rp_n1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      right_hold <= in_data.right_sample;
      n_reg      <= n_cur;
      k          <= '0;
      if (!is_write) begin
        out_data.sample        <= '0;
        out_data.has_sample    <= 1'b0;
        out_data.last          <= 1'b1;
        out_data.read_total    <= '0;
        out_data.dropped_total <= drop_cnt;
      end
    end
    if (cmd.rd_load) begin
      k                      <= k_inc;
      out_data.sample        <= ram_rdata;
      out_data.has_sample    <= 1'b1;
      out_data.last          <= (k_inc == n_reg);
      out_data.read_total    <= sprf_pkg::COUNT_W'(n_reg);
      out_data.dropped_total <= drop_cnt;
    end
  end

endmodule

// ===== src/stereo_pair_ring_fifo.sv =====
// top level of the stereo pair ring fifo: controller plus datapath
// depends on sprf_pkg, sprf_ctrl, sprf_dp, sprf_ram
//
//   channel   handshake               word
//   in        in_valid / in_ready     in_data  (sprf_pkg::in_word_t)
//   out       out_valid / out_ready   out_data (sprf_pkg::out_word_t)
//
// one word in flight at a time; in_ready is high only when idle
// stored pair: left written on accept, right the next cycle; dropped word: accept only
// read: accept issues the first ram read; each sample passes the registered ram read
//   into the single output register; an empty read word is shown in the next cycle
// out_ready low holds the output register and stalls the ram read sequence
// rst is synchronous; pointers, drop counter and state clear, ram contents are not cleared
`timescale 1ns / 1ps

module stereo_pair_ring_fifo #(
  parameter int RING_DEPTH = sprf_pkg::RING_DEPTH_DEF,
  parameter int MAX_READ   = sprf_pkg::MAX_READ_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sprf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sprf_pkg::out_word_t out_data
);

  sprf_pkg::cmd_t    cmd;
  sprf_pkg::status_t status;

  sprf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sprf_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== src/sprf_checker.sv =====
// port level checks of the stereo pair ring fifo, bound to the top level
// depends on sprf_pkg and stereo_pair_ring_fifo_macros.svh
`timescale 1ns / 1ps
`include "stereo_pair_ring_fifo_macros.svh"

module sprf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input sprf_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sprf_pkg::out_word_t out_data
);

  `SPRF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out word changed while stalled")
  `SPRF_ASSERT(a_empty_word, out_valid && !out_data.has_sample |-> out_data.last && out_data.read_total == '0, "bad empty read word")
  `SPRF_ASSERT(a_even_total, out_valid && out_data.has_sample |-> out_data.read_total != '0 && !out_data.read_total[0], "read total not even")
  `SPRF_ASSERT_ALWAYS(a_busy, out_valid |-> !in_ready, "input taken while a word is pending")

endmodule

bind stereo_pair_ring_fifo sprf_checker u_sprf_checker (.*);

// ===== tb/tb.sv =====
// testbench for stereo_pair_ring_fifo: queue-fed driver, checking monitor, ring predictor
// depends on sprf_pkg and the stereo_pair_ring_fifo rtl
`timescale 1ns / 1ps

module tb;

  localparam int RING          = sprf_pkg::RING_DEPTH_DEF;
  localparam int MAX_RD        = sprf_pkg::MAX_READ_DEF;
  localparam int RANDOM_WORDS  = 304;
  localparam int SETTLE_CYCLES = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sprf_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sprf_pkg::out_word_t out_data;

  sprf_pkg::in_word_t  pending_words[$];
  sprf_pkg::out_word_t expected_reads[$];
  int        words_total = 0;
  int        words_accepted = 0;
  int        mismatches = 0;
  int        in_gap = 0;
  int        in_burst = 0;
  int        out_stall = 0;
  int        out_burst = 0;

  logic [sprf_pkg::SAMPLE_W-1:0] ring_model [RING];
  int                            rd_ptr = 0;
  int                            wr_ptr = 0;
  logic [sprf_pkg::DROP_W-1:0]   drop_count = '0;
  logic                          drop_mode = 1'b0;

  stereo_pair_ring_fifo u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int draw_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 16);
    if (r < 75) return $urandom_range(17, MAX_RD - 1);
    if (r < 88) return MAX_RD;
    return $urandom_range(MAX_RD + 1, 127);
  endfunction

  task automatic add_write(input logic [sprf_pkg::SAMPLE_W-1:0] left,
                           input logic [sprf_pkg::SAMPLE_W-1:0] right,
                           input logic pair, input logic eow);
    sprf_pkg::in_word_t w;
    w.opcode        = sprf_pkg::OP_WRITE;
    w.left_sample   = left;
    w.right_sample  = right;
    w.pair_complete = pair;
    w.end_of_write  = eow;
    w.max_count     = sprf_pkg::COUNT_W'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic add_read(input int cnt);
    sprf_pkg::in_word_t w;
    w.opcode        = sprf_pkg::OP_READ;
    w.left_sample   = $urandom;
    w.right_sample  = $urandom;
    w.pair_complete = 1'($urandom);
    w.end_of_write  = 1'($urandom);
    w.max_count     = sprf_pkg::COUNT_W'(cnt);
    pending_words.push_back(w);
  endtask

  // advance the ring model by one accepted word and queue the read words it yields
  task automatic track_ring(input sprf_pkg::in_word_t w);
    int                  n1;
    int                  n2;
    int                  used;
    int                  req;
    int                  n;
    sprf_pkg::out_word_t o;
    if (w.opcode == sprf_pkg::OP_WRITE) begin
      if (!w.pair_complete) begin
        drop_count += 1;
      end else if (drop_mode) begin
        drop_count += 2;
      end else begin
        n1 = (wr_ptr + 1) % RING;
        n2 = (n1 + 1) % RING;
        if (n1 == rd_ptr || n2 == rd_ptr) begin
          drop_count += 2;
          drop_mode = 1'b1;
        end else begin
          ring_model[wr_ptr] = w.left_sample;
          ring_model[n1]     = w.right_sample;
          wr_ptr             = n2;
        end
      end
      if (w.end_of_write) drop_mode = 1'b0;
    end else begin
      used = (wr_ptr + RING - rd_ptr) % RING;
      req  = w.max_count;
      if (req > MAX_RD) req = MAX_RD;
      req = req & ~1;
      n   = (used < req) ? used : req;
      n   = n & ~1;
      if (n == 0) begin
        o               = '0;
        o.last          = 1'b1;
        o.dropped_total = drop_count;
        expected_reads.push_back(o);
      end else begin
        for (int k = 0; k < n; k++) begin
          o.sample        = ring_model[rd_ptr];
          o.has_sample    = 1'b1;
          o.last          = (k == n - 1);
          o.read_total    = sprf_pkg::COUNT_W'(n);
          o.dropped_total = drop_count;
          expected_reads.push_back(o);
          rd_ptr = (rd_ptr + 1) % RING;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_word(input sprf_pkg::out_word_t got);
    sprf_pkg::out_word_t want;
    if (expected_reads.size() == 0) begin
      report_mismatch("word with no read pending", got.sample, '0);
      return;
    end
    want = expected_reads.pop_front();
    if (got.sample !== want.sample)
      report_mismatch("sample", got.sample, want.sample);
    if (got.has_sample !== want.has_sample)
      report_mismatch("has_sample", got.has_sample, want.has_sample);
    if (got.last !== want.last)
      report_mismatch("last", got.last, want.last);
    if (got.read_total !== want.read_total)
      report_mismatch("read_total", got.read_total, want.read_total);
    if (got.dropped_total !== want.dropped_total)
      report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_ring(in_data);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
          in_gap = draw_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) begin
          out_stall = draw_gap(out_burst);
        end else if (!out_valid && $urandom_range(0, 15) == 0) begin
          out_stall = $urandom_range(1, 6);
        end
      end
    end
  end

  initial begin
    int  made;
    int  len;
    bit  lone;

    // empty ring, short and oversized requests, lone words, extreme sample values
    add_read(0);
    add_read(MAX_RD);
    add_write(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_write(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_write(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1);
    add_write(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1);
    add_read(1);
    add_read(3);
    add_read(127);
    add_write(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b1);
    add_write(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    add_read(5);
    add_read(2);
    add_write(32'hDEAD_BEEF, 32'h0000_0001, 1'b0, 1'b0);
    add_write(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 1'b1);
    add_read(MAX_RD + 1);

    made = 0;
    while (made < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 60) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            add_read(draw_count());
            made++;
          end
          lone = (i == len - 1) ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 29) == 0);
          add_write($urandom, $urandom, !lone, (i == len - 1) || ($urandom_range(0, 29) == 0));
          made++;
        end
      end else begin
        add_read(draw_count());
        made++;
      end
    end
    words_total = pending_words.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (words_accepted < words_total || expected_reads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sprf_pkg.sv
src/sprf_ram.sv
src/sprf_ctrl.sv
src/sprf_dp.sv
src/stereo_pair_ring_fifo.sv
src/sprf_checker.sv
tb/tb.sv
